[sv/slsp_pkg.sv]
// Types and constants shared by the serial link shift port modules.
`default_nettype none
package slsp_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic [15:0] ADDR_DATA        = 16'hFF01;
   localparam logic [15:0] ADDR_CTRL        = 16'hFF02;
   localparam logic [9:0]  RELOAD_SLOW      = 10'd512;
   localparam logic [9:0]  RELOAD_FAST      = 10'd16;
   localparam logic [9:0]  TICK_STEP        = 10'd4;
   localparam logic [3:0]  BITS_PER_XFER    = 4'd8;
   localparam logic [7:0]  READ_IDLE        = 8'hFF;
   localparam logic [7:0]  CTRL_ACTIVE      = 8'h80;
   localparam logic [7:0]  CTRL_FILL_COLOUR = 8'h7C;
   localparam logic [7:0]  CTRL_FILL_PLAIN  = 8'h7E;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR_MODE     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTNER_PRESENT = 8'd1;

   typedef struct packed {
      logic colour_mode;
      logic partner_present;
   } cfg_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        partner_bit;
   } item_type;

   typedef struct packed {
      logic [7:0] shift_byte;
      logic [9:0] bit_timer;
      logic       transfer_active;
      logic       fast_clock;
      logic       clock_internal;
      logic [3:0] bit_count;
   } port_state_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       bit_shifted;
      logic       sent_bit;
      logic       interrupt_request;
   } result_type;

endpackage
`default_nettype wire

[sv/slsp_core.sv]
// Next-state and result logic for one item of the serial link shift port.
`default_nettype none
module slsp_core
   import slsp_pkg::*;
(
   input  wire cfg_type        cfg,
   input  wire item_type       item,
   input  wire port_state_type state_cur,
   output port_state_type      state_nxt,
   output result_type          result
);

   logic [9:0] reload;
   logic [3:0] count_inc;

   always_comb begin
      reload    = state_cur.fast_clock ? RELOAD_FAST : RELOAD_SLOW;
      count_inc = state_cur.bit_count + 4'd1;
      state_nxt = state_cur;
      result.read_data         = READ_IDLE;
      result.bit_shifted       = 1'b0;
      result.sent_bit          = 1'b0;
      result.interrupt_request = 1'b0;

      case (item.opcode)
         OP_TICK: begin
            if (state_cur.transfer_active && state_cur.clock_internal) begin
               if (state_cur.bit_timer > TICK_STEP) begin
                  state_nxt.bit_timer = state_cur.bit_timer - TICK_STEP;
               end else begin
                  // timer expired: exchange one bit and reload
                  state_nxt.bit_timer  = reload;
                  result.sent_bit      = state_cur.shift_byte[7];
                  result.bit_shifted   = 1'b1;
                  state_nxt.shift_byte = {state_cur.shift_byte[6:0],
                                          cfg.partner_present ? item.partner_bit : 1'b1};
                  state_nxt.bit_count  = count_inc;
                  if (count_inc >= BITS_PER_XFER) begin
                     state_nxt.transfer_active = 1'b0;
                     result.interrupt_request  = 1'b1;
                  end
               end
            end
         end
         OP_WRITE: begin
            if (item.address == ADDR_DATA) begin
               state_nxt.shift_byte = item.write_data;
            end else if (item.address == ADDR_CTRL) begin
               state_nxt.transfer_active = item.write_data[7];
               state_nxt.clock_internal  = item.write_data[0];
               if (cfg.colour_mode) begin
                  state_nxt.fast_clock = item.write_data[1];
               end
               if (item.write_data[7]) begin
                  // reload uses the speed in effect after this write (written in colour mode, else held)
                  state_nxt.bit_timer = (cfg.colour_mode ? item.write_data[1]
                                         : state_cur.fast_clock) ? RELOAD_FAST : RELOAD_SLOW;
                  state_nxt.bit_count = 4'd0;
               end
            end
         end
         OP_READ: begin
            if (item.address == ADDR_DATA) begin
               result.read_data = state_cur.shift_byte;
            end else if (item.address == ADDR_CTRL) begin
               result.read_data = (state_cur.transfer_active ? CTRL_ACTIVE : 8'h00)
                                | (cfg.colour_mode
                                   ? (CTRL_FILL_COLOUR | {6'd0, state_cur.fast_clock, 1'b0})
                                   : CTRL_FILL_PLAIN)
                                | {7'd0, state_cur.clock_internal};
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

[sv/serial_link_shift_port_unit.sv]
// Serial link shift port: top level with input register, result register and config port.
// Usage:
//   req_* carries one item per handshake: a tick (opcode 0), a register write (1)
//   or a register read (2) of the data byte at 0xFF01 or the control byte at 0xFF02.
//   rsp_* returns exactly one result per item, in order: read data (0xFF when not
//   a mapped read) and the bit exchange flags of a tick.
//   csr_* writes index 0 (colour mode) and 1 (partner present) from bit 0 of
//   csr_wdata; it is always ready and should be written only while the port is idle.
// Timing: an accepted item is held in the input register; when the result register
//   is free or its result is being taken, the item is processed and its result
//   registered there, and rsp_valid is high from then on until the result is taken.
// Throughput: one item per cycle while rsp_ready is high; the state update is a
//   single short pass of decode, a 10-bit decrement and compare, and an 8-bit shift.
// Reset: synchronous; clears both pipeline valids, the port state and the
//   config registers.
// Stall: when rsp_ready is low the result register holds, the input register
//   keeps its item and req_ready drops once both are full; nothing is lost.
`default_nettype none
module serial_link_shift_port_unit
   import slsp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_opcode,
   input  wire  [15:0] req_address,
   input  wire  [7:0]  req_write_data,
   input  wire         req_partner_bit,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_bit_shifted,
   output logic        rsp_sent_bit,
   output logic        rsp_interrupt_request,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [7:0]  csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   item_type       item_ff, item_in;
   logic           item_vld_ff, item_vld_in;
   port_state_type state_ff, state_in, state_nxt;
   result_type     rsp_ff, rsp_in, result;
   logic           rsp_vld_ff, rsp_vld_in;
   logic           out_free;
   logic           advance;

   slsp_core u_core (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (result)
   );

   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign advance   = item_vld_ff && out_free;
   assign req_ready = !item_vld_ff || out_free;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_COLOUR_MODE) begin
            cfg_in.colour_mode = csr_wdata[0];
         end else if (csr_index == CSR_PARTNER_PRESENT) begin
            cfg_in.partner_present = csr_wdata[0];
         end
      end

      item_in     = item_ff;
      item_vld_in = item_vld_ff && !advance;
      if (req_valid && req_ready) begin
         item_in.opcode      = opcode_type'(req_opcode);
         item_in.address     = req_address;
         item_in.write_data  = req_write_data;
         item_in.partner_bit = req_partner_bit;
         item_vld_in         = 1'b1;
      end

      state_in   = advance ? state_nxt : state_ff;
      rsp_in     = advance ? result : rsp_ff;
      rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         item_vld_ff <= 1'b0;
         state_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         item_vld_ff <= item_vld_in;
         state_ff    <= state_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid             = rsp_vld_ff;
   assign rsp_read_data         = rsp_ff.read_data;
   assign rsp_bit_shifted       = rsp_ff.bit_shifted;
   assign rsp_sent_bit          = rsp_ff.sent_bit;
   assign rsp_interrupt_request = rsp_ff.interrupt_request;

endmodule
`default_nettype wire

[dv/tb_serial_link_shift_port_unit.sv]
// Self-checking testbench for the serial link shift port: bus items in, one checked result out.
module tb_serial_link_shift_port_unit;
   import slsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned LONG_HOLD   = 120;
   localparam int unsigned HOLD_AFTER  = 200;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_partner_bit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_bit_shifted;
   logic        rsp_sent_bit;
   logic        rsp_interrupt_request;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   serial_link_shift_port_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_address           (req_address),
      .req_write_data        (req_write_data),
      .req_partner_bit       (req_partner_bit),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_bit_shifted       (rsp_bit_shifted),
      .rsp_sent_bit          (rsp_sent_bit),
      .rsp_interrupt_request (rsp_interrupt_request),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // port state as the bus sees it
   port_state_type port_st  = '0;
   cfg_type        port_cfg = '0;

   item_type   bus_items[$];
   result_type results_due[$];
   item_type   nxt_item;
   item_type   took_item;
   result_type want_rsp;
   result_type port_rsp;

   bit          idle_on = 1'b1;
   int unsigned src_idle = 0;
   int unsigned snk_idle = 0;
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   int unsigned results_checked = 0;
   int unsigned items_taken = 0;
   int unsigned bits_exchanged = 0;
   int unsigned xfers_done = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   task automatic serial_port_update(input item_type it, output result_type res);
      res.read_data         = READ_IDLE;
      res.bit_shifted       = 1'b0;
      res.sent_bit          = 1'b0;
      res.interrupt_request = 1'b0;
      case (it.opcode)
         OP_TICK: begin
            if (port_st.transfer_active && port_st.clock_internal) begin
               if (port_st.bit_timer > TICK_STEP) begin
                  port_st.bit_timer = port_st.bit_timer - TICK_STEP;
               end else begin
                  port_st.bit_timer = port_st.fast_clock ? RELOAD_FAST : RELOAD_SLOW;
                  res.sent_bit = port_st.shift_byte[7];
                  res.bit_shifted = 1'b1;
                  port_st.shift_byte = {port_st.shift_byte[6:0],
                                        port_cfg.partner_present ? it.partner_bit : 1'b1};
                  port_st.bit_count = port_st.bit_count + 4'd1;
                  if (port_st.bit_count >= BITS_PER_XFER) begin
                     port_st.transfer_active = 1'b0;
                     res.interrupt_request = 1'b1;
                  end
               end
            end
         end
         OP_WRITE: begin
            if (it.address == ADDR_DATA) begin
               port_st.shift_byte = it.write_data;
            end else if (it.address == ADDR_CTRL) begin
               port_st.transfer_active = it.write_data[7];
               if (port_cfg.colour_mode)
                  port_st.fast_clock = it.write_data[1];
               port_st.clock_internal = it.write_data[0];
               if (port_st.transfer_active) begin
                  port_st.bit_timer = port_st.fast_clock ? RELOAD_FAST : RELOAD_SLOW;
                  port_st.bit_count = '0;
               end
            end
         end
         OP_READ: begin
            if (it.address == ADDR_DATA) begin
               res.read_data = port_st.shift_byte;
            end else if (it.address == ADDR_CTRL) begin
               res.read_data = port_st.transfer_active ? CTRL_ACTIVE : 8'h00;
               if (port_cfg.colour_mode)
                  res.read_data = res.read_data | CTRL_FILL_COLOUR
                                  | {6'd0, port_st.fast_clock, 1'b0};
               else
                  res.read_data = res.read_data | CTRL_FILL_PLAIN;
               res.read_data[0] = port_st.clock_internal;
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string fname, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, fname, want, got);
         mismatches++;
      end
   endtask

   // result check, config snoop and prediction, all on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with nothing outstanding, actual rd 'h%0h", $time,
                        rsp_read_data);
               mismatches++;
            end else begin
               want_rsp = results_due.pop_front();
               compare_field("read_data", want_rsp.read_data, rsp_read_data);
               compare_field("bit_shifted", want_rsp.bit_shifted, rsp_bit_shifted);
               compare_field("sent_bit", want_rsp.sent_bit, rsp_sent_bit);
               compare_field("interrupt_request", want_rsp.interrupt_request,
                             rsp_interrupt_request);
            end
            results_checked <= results_checked + 1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLOUR_MODE:     port_cfg.colour_mode = csr_wdata[0];
               CSR_PARTNER_PRESENT: port_cfg.partner_present = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            took_item.opcode      = opcode_type'(req_opcode);
            took_item.address     = req_address;
            took_item.write_data  = req_write_data;
            took_item.partner_bit = req_partner_bit;
            serial_port_update(took_item, port_rsp);
            results_due.push_back(port_rsp);
            items_taken++;
            bits_exchanged += port_rsp.bit_shifted;
            xfers_done += port_rsp.interrupt_request;
         end
      end
   end

   // item source
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_idle <= 0;
      end else if (!req_valid || req_ready) begin
         if (src_idle != 0) begin
            req_valid <= 1'b0;
            src_idle <= src_idle - 1;
         end else if (bus_items.size() != 0) begin
            nxt_item = bus_items.pop_front();
            req_valid <= 1'b1;
            req_opcode <= nxt_item.opcode;
            req_address <= nxt_item.address;
            req_write_data <= nxt_item.write_data;
            req_partner_bit <= nxt_item.partner_bit;
            if (idle_on && $urandom_range(0, 7) == 0)
               src_idle <= $urandom_range(1, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result sink; one long hold lets the pipeline fill and push back on req
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         snk_idle <= 0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
      end else if (snk_idle != 0) begin
         rsp_ready <= 1'b0;
         snk_idle <= snk_idle - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         snk_idle <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, results_due.size());
         $display("serial_link_shift_port_unit verification failed");
         $finish;
      end
   end

   task automatic add_item(input opcode_type op, input logic [15:0] addr,
                           input logic [7:0] wd, input logic pb);
      item_type it;
      it.opcode      = op;
      it.address     = addr;
      it.write_data  = wd;
      it.partner_bit = pb;
      bus_items.push_back(it);
   endtask

   task automatic add_noise();
      logic [15:0] addr;
      case ($urandom_range(0, 3))
         0: addr = ADDR_DATA;
         1: addr = ADDR_CTRL;
         2: addr = ADDR_DATA ^ (16'h0001 << $urandom_range(0, 15));
         default: addr = 16'($urandom);
      endcase
      add_item(opcode_type'($urandom_range(0, 3)), addr, 8'($urandom), 1'($urandom));
   endtask

   // load data, start, tick it through with reads and the odd abort or stray item
   task automatic add_transfer(input bit slow);
      logic [7:0] ctrl;
      int ticks;
      int abort_at;
      ctrl = 8'($urandom);
      ctrl[7] = 1'b1;
      ctrl[1] = !slow;
      ctrl[0] = ($urandom_range(0, 7) != 0);
      ticks = slow ? $urandom_range(130, 280) : $urandom_range(24, 44);
      abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ticks - 1) : -1;
      add_item(OP_WRITE, ADDR_DATA, 8'($urandom), 1'($urandom));
      add_item(OP_WRITE, ADDR_CTRL, ctrl, 1'($urandom));
      for (int k = 0; k < ticks; k++) begin
         if (k == abort_at)
            add_item(OP_WRITE, ADDR_CTRL, {1'b0, 7'($urandom)}, 1'($urandom));
         case ($urandom_range(0, 19))
            0: add_item(OP_READ, ADDR_DATA, 8'($urandom), 1'($urandom));
            1: add_item(OP_READ, ADDR_CTRL, 8'($urandom), 1'($urandom));
            2: add_noise();
            default: add_item(OP_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
         endcase
      end
      add_item(OP_READ, ADDR_DATA, 8'($urandom), 1'($urandom));
      add_item(OP_READ, ADDR_CTRL, 8'($urandom), 1'($urandom));
   endtask

   task automatic fill_random(input int n);
      int target;
      target = bus_items.size() + n;
      while (bus_items.size() < target) begin
         if ($urandom_range(0, 9) < 7)
            add_transfer($urandom_range(0, 7) == 0);
         else
            repeat ($urandom_range(1, 6)) add_noise();
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (bus_items.size() != 0 || req_valid || results_due.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= {7'($urandom), v};
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic start_phase(input logic colour, input logic partner, input bit idles);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write(CSR_COLOUR_MODE, colour);
      csr_write(CSR_PARTNER_PRESENT, partner);
      @(negedge clock);
      idle_on = idles;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state, unmapped space, unused opcode, external clock, stop without start
      add_item(OP_READ,  ADDR_DATA, 8'h00, 1'b0);
      add_item(OP_READ,  ADDR_CTRL, 8'hFF, 1'b1);
      add_item(OP_READ,  16'h0000,  8'h00, 1'b0);
      add_item(OP_READ,  16'hFFFF,  8'hFF, 1'b1);
      add_item(OP_NONE,  ADDR_DATA, 8'hFF, 1'b1);
      add_item(OP_TICK,  16'hFFFF,  8'hFF, 1'b1);
      add_item(OP_WRITE, 16'hFF00,  8'hAA, 1'b0);
      add_item(OP_WRITE, ADDR_DATA, 8'hA5, 1'b0);
      add_item(OP_READ,  ADDR_DATA, 8'h00, 1'b0);
      add_item(OP_WRITE, ADDR_CTRL, 8'h80, 1'b0);
      add_item(OP_TICK,  16'h0000,  8'h00, 1'b0);
      add_item(OP_READ,  ADDR_CTRL, 8'h00, 1'b0);
      add_item(OP_WRITE, ADDR_CTRL, 8'hFF, 1'b1);
      add_item(OP_READ,  ADDR_CTRL, 8'h00, 1'b0);
      add_item(OP_TICK,  16'h0000,  8'h00, 1'b1);
      add_item(OP_WRITE, ADDR_CTRL, 8'h01, 1'b0);
      add_item(OP_TICK,  16'h0000,  8'h00, 1'b0);
      add_item(OP_READ,  ADDR_CTRL, 8'h00, 1'b0);
      add_item(OP_WRITE, 16'hFF03,  8'h5A, 1'b0);
      add_item(OP_READ,  16'hFF03,  8'h00, 1'b0);
      add_item(OP_READ,  ADDR_DATA, 8'h00, 1'b0);

      // colour mode with partner: fast start, four ticks to the first bit
      start_phase(1'b1, 1'b1, 1'b1);
      add_item(OP_WRITE, ADDR_CTRL, 8'h83, 1'b0);
      repeat (5) add_item(OP_TICK, 16'h0000, 8'h00, 1'b0);
      add_item(OP_READ, ADDR_CTRL, 8'h00, 1'b0);
      fill_random(50);
      add_item(OP_WRITE, ADDR_CTRL, 8'h03, 1'b0);

      // plain mode keeps the fast bit it had
      start_phase(1'b0, 1'b0, 1'b1);
      fill_random(50);

      // one full slow transfer, no idling
      start_phase(1'b1, 1'b0, 1'b0);
      fill_random(20);
      add_item(OP_WRITE, ADDR_DATA, 8'($urandom), 1'b0);
      add_item(OP_WRITE, ADDR_CTRL, 8'h81, 1'b0);
      repeat (1030) add_item(OP_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
      add_item(OP_READ, ADDR_DATA, 8'h00, 1'b0);
      fill_random(20);
      add_item(OP_WRITE, ADDR_CTRL, 8'h03, 1'b0);

      start_phase(1'b0, 1'b1, 1'b1);
      fill_random(50);

      start_phase(1'b1, 1'b1, 1'b0);
      fill_random(40);

      wait_drained();
      repeat (8) @(posedge clock);
      if (results_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, results_due.size());
         mismatches++;
      end
      $display("Covered %0d bus items: %0d bit exchanges, %0d completed transfers,",
               items_taken, bits_exchanged, xfers_done);
      $display("over all four colour/partner settings with stalls on both sides.");
      if (mismatches == 0)
         $display("serial_link_shift_port_unit verification clean");
      else
         $display("serial_link_shift_port_unit verification failed");
      $finish;
   end

endmodule
